### rtl/core/assert_macros.svh
// Assertion macros shared by the token bucket RTL.
// No dependencies; include with the bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tbd_pkg.sv
// Package for the token bucket delay block: widths, constants and the
// command/status structs between controller and datapath. No dependencies.
package tbd_pkg;

  localparam int RATE_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int ELAPSED_W = 32;
  localparam int DELAY_W   = 32;
  localparam int BAL_W     = 48;
  localparam int REFILL_W  = 64;
  localparam int MILLI_W   = 10;
  localparam int CAP_W     = RATE_W + MILLI_W;
  localparam int SMILLI_W  = SIZE_W + MILLI_W;

  localparam int DIV_STEPS = BAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [MILLI_W-1:0] MILLI         = MILLI_W'(1000);
  localparam logic [RATE_W-1:0]  MIN_CAP_BYTES = RATE_W'(131072);
  localparam logic [BAL_W-1:0]   BAL_MIN       = {1'b1, {(BAL_W-1){1'b0}}};

  typedef struct packed {
    logic capture;
    logic mult;
    logic diff;
    logic refill;
    logic check;
    logic finish;
    logic load_out;
  } tbd_cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic covered;
    logic div_done;
  } tbd_status_t;

endpackage

### rtl/core/tbd_if.sv
// Valid/ready channel interfaces for requests, results and the rate register.
// Depends on tbd_pkg for field widths.
interface tbd_req_if;
  logic                       valid;
  logic                       ready;
  logic [tbd_pkg::SIZE_W-1:0]    packet_size;
  logic [tbd_pkg::ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, output packet_size, output elapsed_ms, input ready);
  modport sink   (input valid, input packet_size, input elapsed_ms, output ready);
endinterface

interface tbd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tbd_pkg::DELAY_W-1:0] delay_ms;

  modport source (output valid, output delay_ms, input ready);
  modport sink   (input valid, input delay_ms, output ready);
endinterface

interface tbd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tbd_pkg::RATE_W-1:0] rate_limit;

  modport source (output valid, output rate_limit, input ready);
  modport sink   (input valid, input rate_limit, output ready);
endinterface

### rtl/core/tbd_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tbd_pkg and assert_macros.svh.
module tbd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tbd_pkg::BAL_W-1:0]     dividend,
  input  logic [tbd_pkg::RATE_W-1:0]    divisor,
  output logic [tbd_pkg::BAL_W-1:0]     quotient,
  output logic [tbd_pkg::RATE_W-1:0]    remainder,
  output logic                          done
);
  import tbd_pkg::*;
  `include "assert_macros.svh"

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [BAL_W-1:0]     quo;
  logic [RATE_W-1:0]    rem;
  logic [RATE_W:0]      shifted;
  logic [RATE_W:0]      trial;
  logic                 fits;

  assign shifted = {rem, quo[BAL_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[BAL_W-2:0], fits};
      rem <= fits ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  `ASSERT_IMPLY(a_done_after_last_step, clk, rst, done, $past(busy) && ($past(cnt) == LAST), "divider done without a full sweep")
endmodule

### rtl/core/tbd_datapath.sv
// Datapath: rate register, bucket state, refill/cap arithmetic and delay.
// Depends on tbd_pkg, tbd_div and assert_macros.svh.
module tbd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tbd_pkg::tbd_cmd_t             cmd,
  output tbd_pkg::tbd_status_t          status,
  input  logic                          cfg_we,
  input  logic [tbd_pkg::RATE_W-1:0]    cfg_rate,
  input  logic [tbd_pkg::SIZE_W-1:0]    packet_size,
  input  logic [tbd_pkg::ELAPSED_W-1:0] elapsed_ms,
  output logic [tbd_pkg::DELAY_W-1:0]   delay_ms
);
  import tbd_pkg::*;
  `include "assert_macros.svh"

  logic [RATE_W-1:0]    rate_limit;
  logic                 bucket_started;
  logic [BAL_W-1:0]     token_balance;
  logic [SIZE_W-1:0]    size_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [REFILL_W-1:0]  refill_r;
  logic [CAP_W-1:0]     cap_r;
  logic [SMILLI_W-1:0]  smilli_r;
  logic [BAL_W:0]       diff_r;
  logic [DELAY_W-1:0]   delay_r;
  logic [DELAY_W-1:0]   delay_out;

  logic [ELAPSED_W-1:0] elapsed_eff;
  logic [RATE_W-1:0]    cap_base;
  logic [BAL_W:0]       bal_ext;
  logic [BAL_W:0]       smilli_ext;
  logic [BAL_W:0]       after_sub;
  logic [BAL_W:0]       needed;
  logic [BAL_W-1:0]     sub_sat;
  logic                 diff_pos;
  logic                 fill_to_cap;
  logic                 covered;
  logic [BAL_W-1:0]     div_quo;
  logic [RATE_W-1:0]    div_rem;
  logic                 div_done;
  logic [DELAY_W:0]     q_round;
  logic [DELAY_W-1:0]   delay_sat;

  // The first request after start-up sees no elapsed time.
  assign elapsed_eff = bucket_started ? elapsed_r : '0;
  assign cap_base    = (rate_limit > MIN_CAP_BYTES) ? rate_limit : MIN_CAP_BYTES;

  assign bal_ext    = {token_balance[BAL_W-1], token_balance};
  assign smilli_ext = (BAL_W+1)'(smilli_r);
  assign after_sub  = bal_ext - smilli_ext;
  assign needed     = smilli_ext - bal_ext;
  assign sub_sat    = (after_sub[BAL_W] != after_sub[BAL_W-1]) ? BAL_MIN
                                                               : after_sub[BAL_W-1:0];

  assign diff_pos    = !diff_r[BAL_W] && (diff_r != '0);
  assign fill_to_cap = !diff_pos || (refill_r >= REFILL_W'(diff_r));
  assign covered     = $signed(bal_ext) >= $signed(smilli_ext);

  // Ceiling of the quotient, saturated to the result width.
  assign q_round   = {1'b0, div_quo[DELAY_W-1:0]} + (DELAY_W+1)'(div_rem != '0);
  assign delay_sat = ((div_quo[BAL_W-1:DELAY_W] != '0) || q_round[DELAY_W])
                     ? '1 : q_round[DELAY_W-1:0];

  tbd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.check && !covered),
    .dividend  (needed[BAL_W-1:0]),
    .divisor   (rate_limit),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit     <= '0;
      bucket_started <= 1'b0;
      token_balance  <= '0;
    end else begin
      if (cfg_we) begin
        rate_limit <= cfg_rate;
      end
      if (cmd.mult && !bucket_started) begin
        bucket_started <= 1'b1;
        token_balance  <= BAL_W'(CAP_W'(rate_limit) * CAP_W'(MILLI));
      end else if (cmd.refill) begin
        token_balance <= fill_to_cap ? BAL_W'(cap_r)
                                     : token_balance + refill_r[BAL_W-1:0];
      end else if (cmd.check && covered) begin
        token_balance <= after_sub[BAL_W-1:0];
      end else if (cmd.finish) begin
        token_balance <= sub_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      size_r    <= packet_size;
      elapsed_r <= elapsed_ms;
      delay_r   <= '0;
    end
    if (cmd.mult) begin
      refill_r <= REFILL_W'(elapsed_eff) * REFILL_W'(rate_limit);
      cap_r    <= CAP_W'(cap_base) * CAP_W'(MILLI);
      smilli_r <= SMILLI_W'(size_r) * SMILLI_W'(MILLI);
    end
    if (cmd.diff) begin
      diff_r <= (BAL_W+1)'(cap_r) - bal_ext;
    end
    if (cmd.finish) begin
      delay_r <= delay_sat;
    end
    if (cmd.load_out) begin
      delay_out <= delay_r;
    end
  end

  assign delay_ms         = delay_out;
  assign status.rate_zero = (rate_limit == '0);
  assign status.covered   = covered;
  assign status.div_done  = div_done;

  `ASSERT_IMPLY(a_balance_within_cap, clk, rst, cmd.check, $signed(bal_ext) <= $signed((BAL_W+1)'(cap_r)), "balance above cap after refill")
  `ASSERT_IMPLY(a_rem_below_rate, clk, rst, div_done, div_rem < rate_limit, "divider remainder not below rate")
endmodule

### rtl/core/tbd_ctrl.sv
// Controller state machine: sequences one request through the datapath.
// Depends on tbd_pkg and assert_macros.svh.
module tbd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  tbd_pkg::tbd_status_t status,
  output tbd_pkg::tbd_cmd_t    cmd
);
  import tbd_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL    = 8'b0000_0010,
    ST_DIFF   = 8'b0000_0100,
    ST_REFILL = 8'b0000_1000,
    ST_CHECK  = 8'b0001_0000,
    ST_DIV    = 8'b0010_0000,
    ST_FIN    = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_valid;
  logic   accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.mult     = (state == ST_MUL);
    cmd.diff     = (state == ST_DIFF);
    cmd.refill   = (state == ST_REFILL);
    cmd.check    = (state == ST_CHECK);
    cmd.finish   = (state == ST_FIN);
    cmd.load_out = (state == ST_EMIT) && (!out_valid || rsp_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = status.rate_zero ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL:    state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_REFILL;
      ST_REFILL: state_next = ST_CHECK;
      ST_CHECK:  state_next = status.covered ? ST_EMIT : ST_DIV;
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN:    state_next = ST_EMIT;
      ST_EMIT: begin
        if (cmd.load_out) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp_valid = out_valid;

  `ASSERT_NEXT(a_div_done_finishes, clk, rst, (state == ST_DIV) && status.div_done, state == ST_FIN, "divide result not taken")
  `ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.load_out, out_valid && (state == ST_IDLE), "result load lost")
endmodule

### rtl/core/token_bucket_delay.sv
// Token bucket rate shaper. Each request (packet_size, elapsed_ms) yields one
// result, delay_ms, the milliseconds to hold the packet (0 = send now). The
// bucket holds signed tokens in thousandths of a byte, refills by
// elapsed_ms * rate_limit, caps at max(131072, rate_limit) bytes and may run
// into debt. rate_limit = 0 bypasses shaping and leaves the state untouched.
// Requests are handled one at a time. A deficit runs the 48-step bit-serial
// divider that computes the ceiling of deficit / rate. The output register
// lets a finished result wait while the next request is already being
// processed. Write rate_limit only while no request is outstanding.
module token_bucket_delay (
  input  logic     clk,
  input  logic     rst,
  tbd_req_if.sink  req,
  tbd_rsp_if.source rsp,
  tbd_cfg_if.sink  cfg
);
  import tbd_pkg::*;

  tbd_cmd_t    cmd;
  tbd_status_t status;

  // Rate register writes are always taken.
  assign cfg.ready = 1'b1;

  // Sequence: capture, multiply, cap difference, refill, cover check, then
  // divide and finish on a deficit only, hand to the output register.
  tbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the bucket state and do the arithmetic.
  tbd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_rate    (cfg.rate_limit),
    .packet_size (req.packet_size),
    .elapsed_ms  (req.elapsed_ms),
    .delay_ms    (rsp.delay_ms)
  );
endmodule
